@@ rtl/todc_pkg.sv @@
// Shared types, codes and limits of the time-of-day clock.
`default_nettype none

package todc_pkg;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_PRESS  = 3'd1,
        MODE_RECORD = 3'd2,
        MODE_UP     = 3'd3,
        MODE_DOWN   = 3'd4,
        MODE_LOAD   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ADJ_NONE    = 3'd0,
        ADJ_HOUR    = 3'd1,
        ADJ_MINUTE  = 3'd2,
        ADJ_SECOND  = 3'd3,
        ADJ_YEAR    = 3'd4,
        ADJ_MONTH   = 3'd5,
        ADJ_DATE    = 3'd6,
        ADJ_WEEKDAY = 3'd7
    } adj_field_t;

    typedef enum logic [1:0] {
        SYNC_NONE  = 2'd0,
        SYNC_READ  = 2'd1,
        SYNC_WRITE = 2'd2
    } sync_t;

    localparam logic [1:0] CFG_SAMPLE_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_LOG_INTERVAL    = 2'd1;
    localparam logic [1:0] CFG_RESYNC_INTERVAL = 2'd2;

    localparam logic [7:0]  SAMPLE_INTERVAL_RESET = 8'd5;
    localparam logic [7:0]  LOG_INTERVAL_RESET    = 8'd5;
    localparam logic [15:0] RESYNC_INTERVAL_RESET = 16'd120;

    localparam logic [6:0] HOUR_MAX    = 7'd23;
    localparam logic [6:0] MINUTE_MAX  = 7'd59;
    localparam logic [6:0] SECOND_MAX  = 7'd59;
    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [6:0] MONTH_MIN   = 7'd1;
    localparam logic [6:0] MONTH_MAX   = 7'd12;
    localparam logic [6:0] DATE_MIN    = 7'd1;
    localparam logic [6:0] DATE_MAX    = 7'd31;
    localparam logic [6:0] WEEKDAY_MAX = 7'd6;
    localparam logic [6:0] FIELD_MIN   = 7'd0;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [2:0] weekday;
    } tod_t;

endpackage

`default_nettype wire

@@ rtl/time_of_day_clock_with_set_mode.sv @@
// Top level of the time-of-day clock with button set mode and interval requests.
//
//  Channel  | Signals                          | Payload
//  ---------+----------------------------------+--------------------------------------
//  cfg      | cfg_valid cfg_ready cfg_index    | register index, 16-bit write data
//           | cfg_data                         |
//  s_axis   | s_tvalid s_tready s_tuser        | event code in tuser, load fields in tdata
//           | s_tdata                          |
//  m_axis   | m_tvalid m_tready m_tdata        | time, date, selector, flags, requests
//
// Each event beat yields one result beat, which is registered and comes out in the cycle after
// the event is accepted, and a new event can be taken every cycle while the output is not stalled.
// The single result register sets the rate: input is accepted while that register is
// empty or is being drained in the same cycle, so a stalled output stops the input.
// Configuration writes are always ready. Reset loads the interval defaults,
// midnight on month 1 date 1, and clears every flag and phase counter.
`default_nettype none

module time_of_day_clock_with_set_mode (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data,

    input  wire         s_tvalid,
    output logic        s_tready,
    // tuser: mode[2:0]
    input  wire  [2:0]  s_tuser,
    // tdata: load_hour[4:0], load_minute[10:5], load_second[16:11], load_year[23:17],
    //        load_month[27:24], load_date[32:28], load_weekday[35:33], zero[39:36]
    input  wire  [39:0] s_tdata,

    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata: hour[4:0], minute[10:5], second[16:11], year[23:17], month[27:24],
    //        date[32:28], weekday[35:33], adjust_field[38:36], recording[39],
    //        sample_request[40], log_request[41], sync_request[43:42], zero[47:44]
    output logic [47:0] m_tdata
);
    import todc_pkg::*;

    logic [7:0]  sample_interval_reg;
    logic [7:0]  log_interval_reg;
    logic [15:0] resync_interval_reg;

    tod_t        tod_reg, tod_next;
    adj_field_t  adjust_reg, adjust_next;
    logic        recording_reg, recording_next;
    logic        write_pending_reg, write_pending_next;
    logic [7:0]  sample_phase_reg, sample_phase_next;
    logic [7:0]  log_phase_reg, log_phase_next;
    logic [15:0] resync_phase_reg, resync_phase_next;

    logic        out_valid_reg;
    logic [43:0] out_data_reg, out_data_next;

    logic        in_beat;
    mode_t       mode;
    tod_t        load_tod;
    tod_t        adj_tod;
    logic        adj_mark;
    tod_t        adv_tod;

    logic [7:0]  sample_inc, log_inc;
    logic [15:0] resync_inc;
    logic        sample_hit, log_hit, resync_hit;
    logic [6:0]  sec_inc, min_inc, hour_inc;
    logic        sreq, lreq, read_req;
    sync_t       sync_code;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_beat   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_data_reg};

    assign mode = mode_t'(s_tuser);

    assign load_tod.hour    = s_tdata[4:0];
    assign load_tod.minute  = s_tdata[10:5];
    assign load_tod.second  = s_tdata[16:11];
    assign load_tod.year    = s_tdata[23:17];
    assign load_tod.month   = s_tdata[27:24];
    assign load_tod.date    = s_tdata[32:28];
    assign load_tod.weekday = s_tdata[35:33];

    todc_field_adjust u_adjust (
        .sel        (adjust_reg),
        .up         (mode == MODE_UP),
        .tod_in     (tod_reg),
        .tod_out    (adj_tod),
        .mark_write (adj_mark)
    );

    // A phase counter fires when the incremented count reaches the interval or wraps;
    // an interval of zero therefore fires on every tick.
    assign sample_inc = sample_phase_reg + 8'd1;
    assign log_inc    = log_phase_reg + 8'd1;
    assign resync_inc = resync_phase_reg + 16'd1;
    assign sample_hit = (sample_inc == 8'd0) || (sample_inc >= sample_interval_reg);
    assign log_hit    = (log_inc == 8'd0) || (log_inc >= log_interval_reg);
    assign resync_hit = (resync_inc == 16'd0) || (resync_inc >= resync_interval_reg);

    // Seconds, minutes and hours carry; the date does not.
    always_comb
    begin
        adv_tod  = tod_reg;
        sec_inc  = {1'b0, tod_reg.second} + 7'd1;
        min_inc  = {1'b0, tod_reg.minute} + 7'd1;
        hour_inc = {2'b00, tod_reg.hour} + 7'd1;
        if (sec_inc > SECOND_MAX)
        begin
            adv_tod.second = 6'd0;
            if (min_inc > MINUTE_MAX)
            begin
                adv_tod.minute = 6'd0;
                adv_tod.hour   = (hour_inc > HOUR_MAX) ? 5'd0 : hour_inc[4:0];
            end
            else
            begin
                adv_tod.minute = min_inc[5:0];
            end
        end
        else
        begin
            adv_tod.second = sec_inc[5:0];
        end
    end

    always_comb
    begin
        tod_next           = tod_reg;
        adjust_next        = adjust_reg;
        recording_next     = recording_reg;
        write_pending_next = write_pending_reg;
        sample_phase_next  = sample_phase_reg;
        log_phase_next     = log_phase_reg;
        resync_phase_next  = resync_phase_reg;
        sreq               = 1'b0;
        lreq               = 1'b0;
        read_req           = 1'b0;
        sync_code          = SYNC_NONE;

        case (mode)
            MODE_TICK:
            begin
                sample_phase_next = sample_hit ? 8'd0 : sample_inc;
                log_phase_next    = log_hit ? 8'd0 : log_inc;
                resync_phase_next = resync_hit ? 16'd0 : resync_inc;
                sreq              = sample_hit;
                lreq              = log_hit && recording_reg;
                if (adjust_reg == ADJ_NONE)
                begin
                    if (resync_hit)
                        read_req = 1'b1;
                    else
                        tod_next = adv_tod;
                end
            end
            MODE_PRESS:
            begin
                adjust_next = adj_field_t'(adjust_reg + 3'd1);
            end
            MODE_RECORD:
            begin
                recording_next = !recording_reg;
            end
            MODE_UP, MODE_DOWN:
            begin
                tod_next = adj_tod;
                if (adj_mark)
                    write_pending_next = 1'b1;
            end
            MODE_LOAD:
            begin
                tod_next = load_tod;
            end
            default:
            begin
                tod_next = tod_reg;
            end
        endcase

        // A due write wins over a read falling on the same event.
        if (write_pending_next && adjust_next == ADJ_NONE)
        begin
            sync_code          = SYNC_WRITE;
            write_pending_next = 1'b0;
        end
        else if (read_req)
        begin
            sync_code = SYNC_READ;
        end

        out_data_next = {sync_code, lreq, sreq, recording_next, adjust_next,
                         tod_next.weekday, tod_next.date, tod_next.month, tod_next.year,
                         tod_next.second, tod_next.minute, tod_next.hour};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_interval_reg <= SAMPLE_INTERVAL_RESET;
            log_interval_reg    <= LOG_INTERVAL_RESET;
            resync_interval_reg <= RESYNC_INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data[7:0];
                CFG_LOG_INTERVAL:    log_interval_reg    <= cfg_data[7:0];
                CFG_RESYNC_INTERVAL: resync_interval_reg <= cfg_data;
                default:             sample_interval_reg <= sample_interval_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tod_reg           <= '{hour: 5'd0, minute: 6'd0, second: 6'd0, year: 7'd0,
                                   month: 4'd1, date: 5'd1, weekday: 3'd0};
            adjust_reg        <= ADJ_NONE;
            recording_reg     <= 1'b0;
            write_pending_reg <= 1'b0;
            sample_phase_reg  <= 8'd0;
            log_phase_reg     <= 8'd0;
            resync_phase_reg  <= 16'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_beat)
            begin
                tod_reg           <= tod_next;
                adjust_reg        <= adjust_next;
                recording_reg     <= recording_next;
                write_pending_reg <= write_pending_next;
                sample_phase_reg  <= sample_phase_next;
                log_phase_reg     <= log_phase_next;
                resync_phase_reg  <= resync_phase_next;
            end
            if (in_beat)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

@@ rtl/todc_field_adjust.sv @@
// Up/down wrap of the time or date field picked by the adjust selector.
`default_nettype none

module todc_field_adjust (
    input  wire todc_pkg::adj_field_t sel,
    input  wire                       up,
    input  wire todc_pkg::tod_t       tod_in,
    output todc_pkg::tod_t            tod_out,
    output logic                      mark_write
);
    import todc_pkg::*;

    function automatic logic [6:0] wrap_step(input logic dir_up, input logic [6:0] v,
                                             input logic [6:0] lo, input logic [6:0] hi);
        logic [6:0] r;
        if (dir_up) begin
            if (v >= hi || v < lo)
                r = lo;
            else
                r = v + 7'd1;
        end
        else begin
            if (v <= lo || v > hi)
                r = hi;
            else
                r = v - 7'd1;
        end
        return r;
    endfunction

    logic [6:0] step_val;

    always_comb
    begin
        tod_out  = tod_in;
        step_val = 7'd0;
        case (sel)
            ADJ_HOUR:
            begin
                step_val = wrap_step(up, {2'b00, tod_in.hour}, FIELD_MIN, HOUR_MAX);
                tod_out.hour = step_val[4:0];
            end
            ADJ_MINUTE:
            begin
                step_val = wrap_step(up, {1'b0, tod_in.minute}, FIELD_MIN, MINUTE_MAX);
                tod_out.minute = step_val[5:0];
            end
            ADJ_SECOND:
            begin
                step_val = wrap_step(up, {1'b0, tod_in.second}, FIELD_MIN, SECOND_MAX);
                tod_out.second = step_val[5:0];
            end
            ADJ_YEAR:
            begin
                step_val = wrap_step(up, tod_in.year, FIELD_MIN, YEAR_MAX);
                tod_out.year = step_val;
            end
            ADJ_MONTH:
            begin
                step_val = wrap_step(up, {3'b000, tod_in.month}, MONTH_MIN, MONTH_MAX);
                tod_out.month = step_val[3:0];
            end
            ADJ_DATE:
            begin
                step_val = wrap_step(up, {2'b00, tod_in.date}, DATE_MIN, DATE_MAX);
                tod_out.date = step_val[4:0];
            end
            ADJ_WEEKDAY:
            begin
                step_val = wrap_step(up, {4'b0000, tod_in.weekday}, FIELD_MIN, WEEKDAY_MAX);
                tod_out.weekday = step_val[2:0];
            end
            default:
            begin
                tod_out = tod_in;
            end
        endcase
    end

    assign mark_write = (sel != ADJ_NONE);

endmodule

`default_nettype wire
